@@ rtl/mlft_pkg.sv @@
// Shared types and constants for the MAC learning forward table.
`timescale 1ns / 1ps

package mlft_pkg;

  // Field widths fixed by the word formats
  localparam int MAC_W  = 48;
  localparam int PORT_W = 4;

  // Default sizes handed to the top level
  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int DEF_PORT_COUNT    = 16;

  // Command queue between front and engine (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // Number of distinct ports the port field can name
  localparam int PORT_SPAN = 1 << PORT_W;

  // Input opcodes
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_FORWARD  = 2'd1;
  localparam logic [1:0] OP_LEAVE    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_HIT         = 2'd0;
  localparam logic [1:0] ST_VIA_PORT    = 2'd1;
  localparam logic [1:0] ST_UNRESOLVED  = 2'd2;
  localparam logic [1:0] ST_NOT_FORWARD = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PORT_W-1:0] dest_port;
    logic              table_full;
  } out_word_t;

  // Command class decided by the front
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_REGISTER,
    KIND_FORWARD,
    KIND_LEAVE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
  } cmd_t;

  // Queue status seen by front and engine
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // One learned table entry
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_RESOLVE,
    ENG_INS_DST
  } eng_state_t;

endpackage

@@ rtl/mac_learning_forward_table.sv @@
// Top level of the MAC learning forward table.
//
//   channel  direction  ports                      handshake
//   input    in         start, busy, in_word       taken when start && !busy
//   result   out        out_valid, out_word        one-cycle strobe, never stalled
//
// Register, leave and unused opcodes finish in the engine idle state. A forward
// passes through the scan state and the resolve state, then the destination insert
// state when a destination found via a port is learned; the fill learned entries
// are scanned one per cycle through the single read port of the table memory.
// Busy is high only while the two-entry command queue is full; the result
// is registered behind the engine. Reset clears count and registrations at once.
`timescale 1ns / 1ps

module mac_learning_forward_table #(
  parameter int TABLE_ENTRIES = mlft_pkg::DEF_TABLE_ENTRIES,
  parameter int PORT_COUNT    = mlft_pkg::DEF_PORT_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mlft_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mlft_pkg::out_word_t out_word
);
  import mlft_pkg::*;

  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // Classify and enqueue
  mlft_front #(
    .PORT_COUNT (PORT_COUNT)
  ) u_front (
    .start    (start),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mlft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Carry out commands
  mlft_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ rtl/mlft_front.sv @@
// Front end: takes input words and classifies them into engine commands.
`timescale 1ns / 1ps

module mlft_front #(
  parameter int PORT_COUNT = mlft_pkg::DEF_PORT_COUNT
) (
  input  logic              start,
  input  mlft_pkg::in_word_t in_word,
  input  mlft_pkg::q_stat_t q_stat,
  output logic              busy,
  output logic              push,
  output mlft_pkg::cmd_t    push_cmd
);
  import mlft_pkg::*;

  logic port_ok;

  // Hold off new words only when the queue has no room
  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  // Register and leave apply only to ports the port table holds
  assign port_ok = int'(in_word.port) < PORT_COUNT;

  always_comb begin
    push_cmd.port    = in_word.port;
    push_cmd.src_mac = in_word.src_mac;
    push_cmd.dst_mac = in_word.dst_mac;
    case (in_word.opcode)
      OP_REGISTER: push_cmd.kind = port_ok ? KIND_REGISTER : KIND_NOP;
      OP_FORWARD:  push_cmd.kind = KIND_FORWARD;
      OP_LEAVE:    push_cmd.kind = port_ok ? KIND_LEAVE : KIND_NOP;
      default:     push_cmd.kind = KIND_NOP;
    endcase
  end

endmodule

@@ rtl/mlft_queue.sv @@
// Short command queue between the front end and the table engine.
`timescale 1ns / 1ps

module mlft_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlft_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output mlft_pkg::cmd_t    head,
  output mlft_pkg::q_stat_t q_stat
);
  import mlft_pkg::*;

  cmd_t           slot_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCW'(QUEUE_DEPTH));

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full && !pop))
    else $error("queue overrun");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("queue underrun");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/mlft_engine.sv @@
// Table engine: port table, learned table scan, learning and result words.
`timescale 1ns / 1ps

module mlft_engine #(
  parameter int TABLE_ENTRIES = mlft_pkg::DEF_TABLE_ENTRIES,
  parameter int PORT_COUNT    = mlft_pkg::DEF_PORT_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mlft_pkg::q_stat_t  q_stat,
  input  mlft_pkg::cmd_t     head,
  output logic               pop,
  output logic               out_valid,
  output mlft_pkg::out_word_t out_word
);
  import mlft_pkg::*;

  localparam int AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW        = $clog2(TABLE_ENTRIES + 1);
  localparam int PortSlots = (PORT_COUNT < PORT_SPAN) ? PORT_COUNT : PORT_SPAN;
  localparam logic [FW-1:0] TableTop = FW'(TABLE_ENTRIES);

  // Control state
  eng_state_t  state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic        chk_r, chk_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [PortSlots-1:0] port_valid_r;

  // Payload state
  cmd_t        cmd_r;
  logic        cmd_load;
  logic        src_found_r, src_found_nxt;
  logic        dst_found_r, dst_found_nxt;
  logic [PORT_W-1:0] dst_port_r, dst_port_nxt;
  logic        pm_found_r, pm_found_nxt;
  logic [PORT_W-1:0] pm_port_r, pm_port_nxt;
  out_word_t   out_word_r, out_word_nxt;
  logic [MAC_W-1:0] port_mac_r [PortSlots];

  // Learned table memory
  entry_t      lmem [TABLE_ENTRIES];
  entry_t      rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t      mem_wdata;

  // Port table controls
  logic        pt_we, pt_clr;

  // Port search and resolve helpers
  logic        pm_found;
  logic [PORT_W-1:0] pm_port;
  logic        src_ins;
  logic [FW-1:0] fill_after;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Registered port search: highest-numbered registered port other than the sender
  always_comb begin
    pm_found = 1'b0;
    pm_port  = '0;
    for (int q = 0; q < PortSlots; q++) begin
      if (port_valid_r[q] && port_mac_r[q] == cmd_r.dst_mac &&
          cmd_r.port != PORT_W'(q)) begin
        pm_found = 1'b1;
        pm_port  = PORT_W'(q);
      end
    end
  end

  // Source goes in when it was not seen and room remains
  assign src_ins    = !src_found_r && (fill_r != TableTop);
  assign fill_after = fill_r + FW'(src_ins);

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    chk_nxt       = 1'b0;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    src_found_nxt = src_found_r;
    dst_found_nxt = dst_found_r;
    dst_port_nxt  = dst_port_r;
    pm_found_nxt  = pm_found_r;
    pm_port_nxt   = pm_port_r;
    pop           = 1'b0;
    cmd_load      = 1'b0;
    pt_we         = 1'b0;
    pt_clr        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[AW-1:0];
    mem_wdata     = '{mac: cmd_r.src_mac, port: cmd_r.port};
    rd_addr       = idx_r[AW-1:0];

    case (state_r)
      ENG_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          cmd_load = 1'b1;
          case (head.kind)
            KIND_FORWARD: begin
              idx_nxt       = '0;
              src_found_nxt = 1'b0;
              dst_found_nxt = 1'b0;
              state_nxt     = ENG_SCAN;
            end
            KIND_REGISTER: begin
              pt_we         = 1'b1;
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: ST_NOT_FORWARD, dest_port: '0, table_full: 1'b0};
            end
            KIND_LEAVE: begin
              pt_clr        = 1'b1;
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: ST_NOT_FORWARD, dest_port: '0, table_full: 1'b0};
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: ST_NOT_FORWARD, dest_port: '0, table_full: 1'b0};
            end
          endcase
        end
      end

      // One entry read per cycle, compared against both MACs in the next cycle
      ENG_SCAN: begin
        pm_found_nxt = pm_found;
        pm_port_nxt  = pm_port;
        if (chk_r) begin
          if (rd_data_r.mac == cmd_r.src_mac) begin
            src_found_nxt = 1'b1;
          end
          if (rd_data_r.mac == cmd_r.dst_mac) begin
            dst_found_nxt = 1'b1;
            dst_port_nxt  = rd_data_r.port;
          end
        end
        if (idx_r < fill_r) begin
          idx_nxt = idx_r + 1'b1;
          chk_nxt = 1'b1;
        end else if (!chk_r) begin
          state_nxt = ENG_RESOLVE;
        end
      end

      // Learn source, resolve destination, issue the result
      ENG_RESOLVE: begin
        state_nxt     = ENG_IDLE;
        out_valid_nxt = 1'b1;
        out_word_nxt.table_full = !src_found_r && !src_ins;
        if (src_ins) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        if (dst_found_r) begin
          out_word_nxt.status    = ST_HIT;
          out_word_nxt.dest_port = dst_port_r;
        end else if (src_ins && cmd_r.dst_mac == cmd_r.src_mac) begin
          // destination is the source just learned
          out_word_nxt.status    = ST_HIT;
          out_word_nxt.dest_port = cmd_r.port;
        end else if (pm_found_r) begin
          out_word_nxt.status    = ST_VIA_PORT;
          out_word_nxt.dest_port = pm_port_r;
          if (fill_after == TableTop) begin
            out_word_nxt.table_full = 1'b1;
          end else begin
            state_nxt = ENG_INS_DST;
          end
        end else begin
          out_word_nxt.status    = ST_UNRESOLVED;
          out_word_nxt.dest_port = '0;
        end
      end

      // Learn destination against the port that resolved it
      ENG_INS_DST: begin
        mem_we    = 1'b1;
        mem_wdata = '{mac: cmd_r.dst_mac, port: pm_port_r};
        fill_nxt  = fill_r + 1'b1;
        state_nxt = ENG_IDLE;
      end

      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ENG_IDLE;
      fill_r       <= '0;
      idx_r        <= '0;
      chk_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      port_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
      for (int q = 0; q < PortSlots; q++) begin
        if (pt_we && head.port == PORT_W'(q)) begin
          port_valid_r[q] <= 1'b1;
        end else if (pt_clr && head.port == PORT_W'(q)) begin
          port_valid_r[q] <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_r <= head;
    end
    src_found_r <= src_found_nxt;
    dst_found_r <= dst_found_nxt;
    dst_port_r  <= dst_port_nxt;
    pm_found_r  <= pm_found_nxt;
    pm_port_r   <= pm_port_nxt;
    out_word_r  <= out_word_nxt;
    for (int q = 0; q < PortSlots; q++) begin
      if (pt_we && head.port == PORT_W'(q)) begin
        port_mac_r[q] <= head.src_mac;
      end
    end
  end

  // Learned table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lmem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= lmem[rd_addr];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TableTop)
    else $error("fill count beyond table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (fill_r < TableTop))
    else $error("table write while full");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ENG_IDLE || $past(state_r) == ENG_RESOLVE))
    else $error("result from unexpected state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.table_full) |-> (out_word_r.status != ST_NOT_FORWARD))
    else $error("table full flagged on non-forward word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_INS_DST) |-> $past(state_r) == ENG_RESOLVE)
    else $error("destination insert without resolve");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the MAC learning forward table.
`timescale 1ns / 1ps

module testbench;
  import mlft_pkg::*;

  localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam int PORT_COUNT    = DEF_PORT_COUNT;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int PHASE_A_ITEMS = 500;   // small MAC pool, table stays below full
  localparam int NARROW_POOL   = 14;
  localparam int WIDE_POOL     = 64;
  localparam int TAIL_CYCLES   = 64;    // idle time after the last awaited result
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  logic [MAC_W-1:0] mac_pool [WIDE_POOL];
  int burst_left = 0;
  int cycle_count = 0;

  // Forward table predictor plus queue of awaited result words
  class forward_scoreboard;
    logic [MAC_W-1:0]  entry_mac    [TABLE_ENTRIES];
    logic [PORT_W-1:0] entry_port   [TABLE_ENTRIES];
    bit                entry_used   [TABLE_ENTRIES];
    logic [MAC_W-1:0]  station_mac  [PORT_COUNT];
    bit                station_on   [PORT_COUNT];
    out_word_t         awaited [$];
    int                errors = 0;

    function int lookup_mac(logic [MAC_W-1:0] mac);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (entry_used[i] && entry_mac[i] == mac) return i;
      return -1;
    endfunction

    // Lowest free slot takes the new entry; 0 when the table is full
    function bit learn_mac(logic [MAC_W-1:0] mac, logic [PORT_W-1:0] prt);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!entry_used[i]) begin
          entry_used[i] = 1'b1;
          entry_mac[i]  = mac;
          entry_port[i] = prt;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Accepted input word: update state, queue the expected result
    function void take_word(in_word_t w);
      out_word_t r;
      int        hit;
      int        found;
      r.status     = ST_NOT_FORWARD;
      r.dest_port  = '0;
      r.table_full = 1'b0;
      case (w.opcode)
        OP_REGISTER: begin
          if (w.port < PORT_COUNT) begin
            station_mac[w.port] = w.src_mac;
            station_on[w.port]  = 1'b1;
          end
        end
        OP_LEAVE: begin
          if (w.port < PORT_COUNT) station_on[w.port] = 1'b0;
        end
        OP_FORWARD: begin
          // learn source only if absent; existing entries are never refreshed
          if (lookup_mac(w.src_mac) < 0)
            if (!learn_mac(w.src_mac, w.port)) r.table_full = 1'b1;
          hit = lookup_mac(w.dst_mac);
          if (hit >= 0) begin
            r.status    = ST_HIT;
            r.dest_port = entry_port[hit];
          end else begin
            // other registered ports, highest number wins
            found = -1;
            for (int q = 0; q < PORT_COUNT; q++)
              if (q != w.port && station_on[q] && station_mac[q] == w.dst_mac) found = q;
            if (found >= 0) begin
              if (!learn_mac(w.dst_mac, PORT_W'(found))) r.table_full = 1'b1;
              r.status    = ST_VIA_PORT;
              r.dest_port = PORT_W'(found);
            end else begin
              r.status = ST_UNRESOLVED;
            end
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void match_result(out_word_t got);
      out_word_t exp_r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: status %0d port %0d full %0d", $time,
                   got.status, got.dest_port, got.table_full);
        return;
      end
      exp_r = awaited.pop_front();
      if (got.status !== exp_r.status || got.dest_port !== exp_r.dest_port ||
          got.table_full !== exp_r.table_full) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: expected status %0d port %0d full %0d, got %0d %0d %0d",
                   $time, exp_r.status, exp_r.dest_port, exp_r.table_full,
                   got.status, got.dest_port, got.table_full);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  forward_scoreboard sb = new();

  mac_learning_forward_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PORT_COUNT   (PORT_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result check first, then note the word taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.match_result(out_word);
      if (start && !busy) sb.take_word(in_word);
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  function automatic in_word_t mk(logic [1:0] op, logic [PORT_W-1:0] prt,
                                  logic [MAC_W-1:0] smac, logic [MAC_W-1:0] dmac);
    in_word_t w;
    w.opcode  = op;
    w.port    = prt;
    w.src_mac = smac;
    w.dst_mac = dmac;
    return w;
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac(int pool_n, bit fresh);
    if (fresh && $urandom_range(0, 9) == 0) return rand_mac();
    return mac_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Mostly forwards over a shared MAC pool, some port churn, a little noise
  function automatic in_word_t random_word(int pool_n, bit fresh);
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    w = mk(2'($urandom), 4'($urandom), rand_mac(), rand_mac());
    if (roll < 62) begin
      w.opcode  = OP_FORWARD;
      w.src_mac = pick_mac(pool_n, fresh);
      w.dst_mac = ($urandom_range(0, 19) == 0) ? w.src_mac : pick_mac(pool_n, fresh);
    end else if (roll < 80) begin
      w.opcode  = OP_REGISTER;
      w.src_mac = pick_mac(pool_n, fresh);
    end else if (roll < 93) begin
      w.opcode = OP_LEAVE;
    end else begin
      w.opcode = OP_UNUSED;
    end
    return w;
  endfunction

  // Idle gap before the next word: mostly none, some short, a few long
  function automatic int next_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 58) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present a word at the falling edge and hold it until taken
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    in_word_t w;
    int       counted;
    for (int i = 0; i < WIDE_POOL; i++) mac_pool[i] = rand_mac();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, port resolution, tie-break, sender exclusion
    send_word(mk(OP_FORWARD,  4'd0,  48'h0, 48'hFFFF_FFFF_FFFF), next_gap());
    send_word(mk(OP_REGISTER, 4'd15, 48'hFFFF_FFFF_FFFF, 48'h0), next_gap());
    send_word(mk(OP_REGISTER, 4'd0,  48'h0A0B_0C0D_0E0F, 48'hFFFF_FFFF_FFFF), next_gap());
    send_word(mk(OP_FORWARD,  4'd0,  48'h1111, 48'hFFFF_FFFF_FFFF), next_gap());
    send_word(mk(OP_FORWARD,  4'd15, 48'h2222, 48'hFFFF_FFFF_FFFF), next_gap());
    send_word(mk(OP_REGISTER, 4'd9,  48'h5555_AAAA_5555, 48'h0), next_gap());
    send_word(mk(OP_REGISTER, 4'd12, 48'h5555_AAAA_5555, 48'h0), next_gap());
    send_word(mk(OP_FORWARD,  4'd1,  48'h3333, 48'h5555_AAAA_5555), next_gap());
    send_word(mk(OP_REGISTER, 4'd13, 48'hAAAA_5555_AAAA, 48'h0), next_gap());
    send_word(mk(OP_REGISTER, 4'd14, 48'hAAAA_5555_AAAA, 48'h0), next_gap());
    send_word(mk(OP_FORWARD,  4'd14, 48'h4444, 48'hAAAA_5555_AAAA), next_gap());
    // source equals destination
    send_word(mk(OP_FORWARD,  4'd2,  48'h8000_0000_0000, 48'h8000_0000_0000), next_gap());
    // a port that left no longer resolves
    send_word(mk(OP_REGISTER, 4'd6,  48'h1234_5678_9ABC, 48'h0), next_gap());
    send_word(mk(OP_LEAVE,    4'd6,  48'h0, 48'h0), next_gap());
    send_word(mk(OP_FORWARD,  4'd3,  48'h0, 48'h1234_5678_9ABC), next_gap());
    // leave of an unregistered port, unused opcode
    send_word(mk(OP_LEAVE,    4'd10, 48'h0, 48'h0), next_gap());
    send_word(mk(OP_UNUSED,   4'd7,  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF), next_gap());
    // re-registration replaces the port MAC
    send_word(mk(OP_REGISTER, 4'd0,  48'hDEAD_BEEF_0001, 48'h0), next_gap());
    send_word(mk(OP_FORWARD,  4'd5,  48'h5555, 48'h0A0B_0C0D_0E0F), next_gap());
    send_word(mk(OP_FORWARD,  4'd5,  48'h5555, 48'hDEAD_BEEF_0001), next_gap());
    // known source is not moved; learned entries survive a leave
    send_word(mk(OP_FORWARD,  4'd15, 48'hFFFF_FFFF_FFFF, 48'h0), next_gap());
    send_word(mk(OP_LEAVE,    4'd15, 48'h0, 48'h0), next_gap());
    send_word(mk(OP_FORWARD,  4'd1,  48'h6666, 48'hFFFF_FFFF_FFFF), next_gap());

    // Random: first a narrow pool below capacity, then a wide one that fills it
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted < PHASE_A_ITEMS) w = random_word(NARROW_POOL, 1'b0);
      else w = random_word(WIDE_POOL, 1'b1);
      counted++;
      send_word(w, next_gap());
    end
    start = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
